>>> rtl/core/tocp_pkg.sv
// ----------------------------------------------------------------------------
// tocp_pkg
// Shared widths, constants and item types of the off-center point core.
// ----------------------------------------------------------------------------
`default_nettype none

package tocp_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int K_FRAC     = 16;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 48;
  localparam int CFG_W      = 32;

  localparam int DW   = COORD_BITS + 1;
  localparam int SQW  = 2 * DW;
  localparam int DETW = 2 * DW + 1;
  localparam int DENW = DETW + 1;
  localparam int PRW  = DW + SQW + 1;
  localparam int NUMW = PRW + 1;
  localparam int DVW  = NUMW + FRAC_BITS;
  localparam int KW   = CFG_W + 1;
  localparam int KPW  = KW + 1 + DW;
  localparam int VW   = KPW + 1;
  localparam int QW   = (DVW > 64) ? DVW : 64;

  localparam int OFF_SHL = (FRAC_BITS >= K_FRAC + 1) ? FRAC_BITS - (K_FRAC + 1) : 0;
  localparam int OFF_SHR = (FRAC_BITS >= K_FRAC + 1) ? 0 : (K_FRAC + 1) - FRAC_BITS;

  localparam logic [63:0]        CLAMP_LIM = (64'd1 << 62) - 64'd1;
  localparam logic signed [63:0] OUT_MAX   = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN   = -OUT_MAX - 64'sd1;
  localparam logic [CFG_W-1:0]   OFF_RESET = 32'd65536;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] a_y;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] b_y;
    logic signed [IN_W-1:0] c_x;
    logic signed [IN_W-1:0] c_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic                         degen;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [DW-1:0]         bax;
    logic signed [DW-1:0]         bay;
    logic                         use_of;
    logic signed [63:0]           ox;
    logic signed [63:0]           oy;
    logic                         sato;
    logic                         negx;
    logic                         negy;
  } side_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tocp_front.sv
// ----------------------------------------------------------------------------
// tocp_front
// Five stages: differences, squares and area, numerator products and edge
// choice, numerator magnitudes and off-center products, off-center offset.
// ----------------------------------------------------------------------------
`default_nettype none

module tocp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_vld,
  input  tocp_pkg::in_t                  in_data,
  input  logic [tocp_pkg::CFG_W-1:0]     off_constant,
  output logic                           dv_vld,
  output tocp_pkg::side_t                dv_side,
  output logic [tocp_pkg::DENW-1:0]      dv_den,
  output logic [tocp_pkg::DVW-1:0]       dv_numx,
  output logic [tocp_pkg::DVW-1:0]       dv_numy
);

  localparam int CW   = tocp_pkg::COORD_BITS;
  localparam int DW   = tocp_pkg::DW;
  localparam int SQW  = tocp_pkg::SQW;
  localparam int DETW = tocp_pkg::DETW;
  localparam int DENW = tocp_pkg::DENW;
  localparam int PRW  = tocp_pkg::PRW;
  localparam int NUMW = tocp_pkg::NUMW;
  localparam int DVW  = tocp_pkg::DVW;
  localparam int KPW  = tocp_pkg::KPW;
  localparam int VW   = tocp_pkg::VW;
  localparam int FB   = tocp_pkg::FRAC_BITS;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic signed [CW-1:0] ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r, ax4_r, ay4_r;
  logic signed [DW-1:0] bax1_r, bay1_r, cax1_r, cay1_r, bcx1_r, bcy1_r;
  logic signed [DW-1:0] bax1_nxt, bay1_nxt, cax1_nxt, cay1_nxt, bcx1_nxt, bcy1_nxt;
  logic signed [DW-1:0] bax2_r, bay2_r, cax2_r, cay2_r, bcx2_r, bcy2_r;
  logic signed [DW-1:0] bax3_r, bay3_r, bax4_r, bay4_r;
  logic [SQW-1:0]       ab2_r, ac2_r, bc2_r, ab2_nxt, ac2_nxt, bc2_nxt;
  logic signed [DETW-1:0] det2_r, det2_nxt;
  logic signed [PRW-1:0] pcx3_r, pbx3_r, pba3_r, pcb3_r;
  logic signed [PRW-1:0] pcx3_nxt, pbx3_nxt, pba3_nxt, pcb3_nxt;
  logic signed [DW-1:0] ex3_r, ey3_r, ex3_nxt, ey3_nxt, ex4_r, ey4_r;
  logic                 sneg3_r, useof3_r, degen3_r, sneg3_nxt, useof3_nxt, degen3_nxt;
  logic                 sneg4_r, useof4_r, degen4_r;
  logic [DENW-1:0]      den3_r, den4_r, den5_r;
  logic [NUMW-1:0]      magx4_r, magy4_r, magx4_nxt, magy4_nxt;
  logic                 negx4_r, negy4_r;
  logic signed [NUMW-1:0] numx4, numy4;
  logic signed [KPW-1:0] kx4_r, ky4_r, kx4_nxt, ky4_nxt;
  logic signed [VW-1:0] exs5, eys5, vx5, vy5;
  logic [63:0]          mvx5, mvy5, shx5, shy5, clx5, cly5;
  logic                 satx5, saty5;
  tocp_pkg::side_t      side5_r, side5_nxt;
  logic [DVW-1:0]       numx5_r, numy5_r;

  // stage 1: sign-extend and form edge vectors
  always_comb begin
    bax1_nxt = DW'($signed(in_data.b_x[CW-1:0])) - DW'($signed(in_data.a_x[CW-1:0]));
    bay1_nxt = DW'($signed(in_data.b_y[CW-1:0])) - DW'($signed(in_data.a_y[CW-1:0]));
    cax1_nxt = DW'($signed(in_data.c_x[CW-1:0])) - DW'($signed(in_data.a_x[CW-1:0]));
    cay1_nxt = DW'($signed(in_data.c_y[CW-1:0])) - DW'($signed(in_data.a_y[CW-1:0]));
    bcx1_nxt = DW'($signed(in_data.b_x[CW-1:0])) - DW'($signed(in_data.c_x[CW-1:0]));
    bcy1_nxt = DW'($signed(in_data.b_y[CW-1:0])) - DW'($signed(in_data.c_y[CW-1:0]));
  end

  // stage 2: squared lengths and area
  always_comb begin
    logic signed [SQW-1:0] s0, s1, s2, s3, s4, s5;
    s0 = bax1_r * bax1_r;
    s1 = bay1_r * bay1_r;
    s2 = cax1_r * cax1_r;
    s3 = cay1_r * cay1_r;
    s4 = bcx1_r * bcx1_r;
    s5 = bcy1_r * bcy1_r;
    ab2_nxt  = $unsigned(s0) + $unsigned(s1);
    ac2_nxt  = $unsigned(s2) + $unsigned(s3);
    bc2_nxt  = $unsigned(s4) + $unsigned(s5);
    det2_nxt = bax1_r * cay1_r - bay1_r * cax1_r;
  end

  // stage 3: numerator products and shortest edge
  always_comb begin
    logic sel_ab, sel_ac;
    pcx3_nxt = cay2_r * $signed({1'b0, ab2_r});
    pbx3_nxt = bay2_r * $signed({1'b0, ac2_r});
    pba3_nxt = bax2_r * $signed({1'b0, ac2_r});
    pcb3_nxt = cax2_r * $signed({1'b0, ab2_r});
    sel_ab = (ab2_r < ac2_r) && (ab2_r < bc2_r);
    sel_ac = !sel_ab && (ac2_r < bc2_r);
    if (sel_ab) begin
      ex3_nxt = bax2_r;
      ey3_nxt = bay2_r;
    end else if (sel_ac) begin
      ex3_nxt = cax2_r;
      ey3_nxt = cay2_r;
    end else begin
      ex3_nxt = bcx2_r;
      ey3_nxt = bcy2_r;
    end
    sneg3_nxt  = sel_ac;
    useof3_nxt = !sel_ab && !sel_ac;
    degen3_nxt = det2_r[DETW-1] || (det2_r == '0);
  end

  // stage 4: numerator magnitudes and scaled edge products
  always_comb begin
    numx4     = pcx3_r - pbx3_r;
    numy4     = pba3_r - pcb3_r;
    magx4_nxt = numx4[NUMW-1] ? NUMW'(-numx4) : NUMW'(numx4);
    magy4_nxt = numy4[NUMW-1] ? NUMW'(-numy4) : NUMW'(numy4);
    kx4_nxt   = $signed({1'b0, off_constant, 1'b0}) * ex3_r;
    ky4_nxt   = $signed({1'b0, off_constant, 1'b0}) * ey3_r;
  end

  // stage 5: off-center offset, rescaled and clamped
  always_comb begin
    exs5 = VW'(ex4_r) <<< tocp_pkg::K_FRAC;
    eys5 = VW'(ey4_r) <<< tocp_pkg::K_FRAC;
    vx5  = sneg4_r ? exs5 + VW'(ky4_r) : exs5 - VW'(ky4_r);
    vy5  = sneg4_r ? eys5 - VW'(kx4_r) : eys5 + VW'(kx4_r);
    mvx5 = vx5[VW-1] ? 64'(-vx5) : 64'(vx5);
    mvy5 = vy5[VW-1] ? 64'(-vy5) : 64'(vy5);
    shx5 = (mvx5 << tocp_pkg::OFF_SHL) >> tocp_pkg::OFF_SHR;
    shy5 = (mvy5 << tocp_pkg::OFF_SHL) >> tocp_pkg::OFF_SHR;
    satx5 = shx5 > tocp_pkg::CLAMP_LIM;
    saty5 = shy5 > tocp_pkg::CLAMP_LIM;
    clx5 = satx5 ? tocp_pkg::CLAMP_LIM : shx5;
    cly5 = saty5 ? tocp_pkg::CLAMP_LIM : shy5;
    side5_nxt.degen  = degen4_r;
    side5_nxt.ax     = ax4_r;
    side5_nxt.ay     = ay4_r;
    side5_nxt.bax    = bax4_r;
    side5_nxt.bay    = bay4_r;
    side5_nxt.use_of = useof4_r;
    side5_nxt.ox     = vx5[VW-1] ? -$signed(clx5) : $signed(clx5);
    side5_nxt.oy     = vy5[VW-1] ? -$signed(cly5) : $signed(cly5);
    side5_nxt.sato   = satx5 || saty5;
    side5_nxt.negx   = negx4_r;
    side5_nxt.negy   = negy4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r  <= $signed(in_data.a_x[CW-1:0]);
      ay1_r  <= $signed(in_data.a_y[CW-1:0]);
      bax1_r <= bax1_nxt;
      bay1_r <= bay1_nxt;
      cax1_r <= cax1_nxt;
      cay1_r <= cay1_nxt;
      bcx1_r <= bcx1_nxt;
      bcy1_r <= bcy1_nxt;

      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      bax2_r <= bax1_r;
      bay2_r <= bay1_r;
      cax2_r <= cax1_r;
      cay2_r <= cay1_r;
      bcx2_r <= bcx1_r;
      bcy2_r <= bcy1_r;
      ab2_r  <= ab2_nxt;
      ac2_r  <= ac2_nxt;
      bc2_r  <= bc2_nxt;
      det2_r <= det2_nxt;

      ax3_r    <= ax2_r;
      ay3_r    <= ay2_r;
      bax3_r   <= bax2_r;
      bay3_r   <= bay2_r;
      pcx3_r   <= pcx3_nxt;
      pbx3_r   <= pbx3_nxt;
      pba3_r   <= pba3_nxt;
      pcb3_r   <= pcb3_nxt;
      ex3_r    <= ex3_nxt;
      ey3_r    <= ey3_nxt;
      sneg3_r  <= sneg3_nxt;
      useof3_r <= useof3_nxt;
      degen3_r <= degen3_nxt;
      den3_r   <= $unsigned({det2_r, 1'b0});

      ax4_r    <= ax3_r;
      ay4_r    <= ay3_r;
      bax4_r   <= bax3_r;
      bay4_r   <= bay3_r;
      magx4_r  <= magx4_nxt;
      magy4_r  <= magy4_nxt;
      negx4_r  <= numx4[NUMW-1];
      negy4_r  <= numy4[NUMW-1];
      kx4_r    <= kx4_nxt;
      ky4_r    <= ky4_nxt;
      ex4_r    <= ex3_r;
      ey4_r    <= ey3_r;
      sneg4_r  <= sneg3_r;
      useof4_r <= useof3_r;
      degen4_r <= degen3_r;
      den4_r   <= den3_r;

      side5_r <= side5_nxt;
      den5_r  <= den4_r;
      numx5_r <= {magx4_r, {FB{1'b0}}};
      numy5_r <= {magy4_r, {FB{1'b0}}};
    end
  end

  assign dv_vld  = v5_r;
  assign dv_side = side5_r;
  assign dv_den  = den5_r;
  assign dv_numx = numx5_r;
  assign dv_numy = numy5_r;

endmodule

`default_nettype wire

>>> rtl/core/tocp_div.sv
// ----------------------------------------------------------------------------
// tocp_div
// Pipelined restoring divider, one quotient bit per stage for x and y,
// sharing the divisor; side data rides along with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module tocp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  tocp_pkg::side_t            in_side,
  input  logic [tocp_pkg::DENW-1:0]  in_den,
  input  logic [tocp_pkg::DVW-1:0]   in_numx,
  input  logic [tocp_pkg::DVW-1:0]   in_numy,
  output logic                       q_vld,
  output tocp_pkg::side_t            q_side,
  output logic [tocp_pkg::DVW-1:0]   q_x,
  output logic [tocp_pkg::DVW-1:0]   q_y
);

  localparam int DENW = tocp_pkg::DENW;
  localparam int DVW  = tocp_pkg::DVW;

  logic                 vld_r  [1:DVW];
  tocp_pkg::side_t      side_r [1:DVW];
  logic [DENW-1:0]      den_r  [1:DVW];
  logic [DENW-1:0]      rx_r   [1:DVW];
  logic [DENW-1:0]      ry_r   [1:DVW];
  logic [DVW-1:0]       qx_r   [1:DVW];
  logic [DVW-1:0]       qy_r   [1:DVW];

  for (genvar k = 0; k < DVW; k++) begin : g_stage
    logic            v_in;
    tocp_pkg::side_t s_in;
    logic [DENW-1:0] d_in, rx_in, ry_in;
    logic [DVW-1:0]  qx_in, qy_in;
    logic [DENW:0]   tx, ty;
    logic            gex, gey;

    if (k == 0) begin : g_head
      assign v_in  = in_vld;
      assign s_in  = in_side;
      assign d_in  = in_den;
      assign rx_in = '0;
      assign ry_in = '0;
      assign qx_in = in_numx;
      assign qy_in = in_numy;
    end else begin : g_body
      assign v_in  = vld_r[k];
      assign s_in  = side_r[k];
      assign d_in  = den_r[k];
      assign rx_in = rx_r[k];
      assign ry_in = ry_r[k];
      assign qx_in = qx_r[k];
      assign qy_in = qy_r[k];
    end

    assign tx  = {rx_in, qx_in[DVW-1]};
    assign ty  = {ry_in, qy_in[DVW-1]};
    assign gex = tx >= {1'b0, d_in};
    assign gey = ty >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k+1] <= s_in;
        den_r[k+1]  <= d_in;
        rx_r[k+1]   <= gex ? DENW'(tx - {1'b0, d_in}) : tx[DENW-1:0];
        ry_r[k+1]   <= gey ? DENW'(ty - {1'b0, d_in}) : ty[DENW-1:0];
        qx_r[k+1]   <= {qx_in[DVW-2:0], gex};
        qy_r[k+1]   <= {qy_in[DVW-2:0], gey};
      end
    end
  end

  assign q_vld  = vld_r[DVW];
  assign q_side = side_r[DVW];
  assign q_x    = qx_r[DVW];
  assign q_y    = qy_r[DVW];

endmodule

`default_nettype wire

>>> rtl/core/tocp_back.sv
// ----------------------------------------------------------------------------
// tocp_back
// Six stages: clamp circumcenter offset, partial products, squares,
// distance sums, point choice, final add with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tocp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      q_vld,
  input  tocp_pkg::side_t           q_side,
  input  logic [tocp_pkg::DVW-1:0]  q_x,
  input  logic [tocp_pkg::DVW-1:0]  q_y,
  output logic                      out_vld,
  output tocp_pkg::out_t            out_data
);

  localparam int QW = tocp_pkg::QW;
  localparam int FB = tocp_pkg::FRAC_BITS;

  typedef struct packed {
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] ofx;
    logic signed [63:0] ofy;
    logic signed [63:0] ox;
    logic signed [63:0] oy;
    logic               satd;
    logic               sato;
    logic               degen;
    logic signed [tocp_pkg::COORD_BITS-1:0] ax;
    logic signed [tocp_pkg::COORD_BITS-1:0] ay;
  } bk_t;

  typedef struct packed {
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p3;
  } pp_t;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  bk_t  bk1_r, bk2_r, bk3_r, bk4_r, bk1_nxt;
  logic signed [63:0] cx1_r, cy1_r, cx1_nxt, cy1_nxt;
  pp_t  pcx2_r, pcy2_r, pox2_r, poy2_r;
  pp_t  pcx2_nxt, pcy2_nxt, pox2_nxt, poy2_nxt;
  logic [127:0] scx3_r, scy3_r, sox3_r, soy3_r;
  logic [127:0] cd4_r, od4_r;
  logic signed [63:0] fx5_r, fy5_r, fx5_nxt, fy5_nxt;
  logic sat5_r, sat5_nxt, degen5_r;
  logic signed [tocp_pkg::COORD_BITS-1:0] ax5_r, ay5_r;
  tocp_pkg::out_t out6_r, out6_nxt;

  function automatic pp_t split_sq(input logic signed [63:0] v);
    logic [63:0] m;
    m = tocp_pkg::mag64(v);
    split_sq.p0 = m[31:0] * m[31:0];
    split_sq.p1 = m[31:0] * m[63:32];
    split_sq.p3 = m[63:32] * m[63:32];
  endfunction

  function automatic logic [127:0] join_sq(input pp_t p);
    join_sq = 128'(p.p0) + (128'(p.p1) << 33) + (128'(p.p3) << 64);
  endfunction

  function automatic logic signed [63:0] sat48(input logic signed [63:0] v,
                                               output logic sat);
    sat = 1'b0;
    sat48 = v;
    if (v > tocp_pkg::OUT_MAX) begin
      sat = 1'b1;
      sat48 = tocp_pkg::OUT_MAX;
    end else if (v < tocp_pkg::OUT_MIN) begin
      sat = 1'b1;
      sat48 = tocp_pkg::OUT_MIN;
    end
  endfunction

  // stage 1: clamp quotients and apply signs
  always_comb begin
    logic [QW-1:0] qx, qy;
    logic          sx, sy;
    logic [63:0]   mx, my;
    qx = QW'(q_x);
    qy = QW'(q_y);
    sx = qx > QW'(tocp_pkg::CLAMP_LIM);
    sy = qy > QW'(tocp_pkg::CLAMP_LIM);
    mx = sx ? tocp_pkg::CLAMP_LIM : qx[63:0];
    my = sy ? tocp_pkg::CLAMP_LIM : qy[63:0];
    bk1_nxt.dx    = q_side.negx ? -$signed(mx) : $signed(mx);
    bk1_nxt.dy    = q_side.negy ? -$signed(my) : $signed(my);
    bk1_nxt.ofx   = q_side.use_of ? (64'(q_side.bax) <<< FB) : 64'sd0;
    bk1_nxt.ofy   = q_side.use_of ? (64'(q_side.bay) <<< FB) : 64'sd0;
    bk1_nxt.ox    = q_side.ox;
    bk1_nxt.oy    = q_side.oy;
    bk1_nxt.satd  = sx || sy;
    bk1_nxt.sato  = q_side.sato;
    bk1_nxt.degen = q_side.degen;
    bk1_nxt.ax    = q_side.ax;
    bk1_nxt.ay    = q_side.ay;
    cx1_nxt = bk1_nxt.dx - bk1_nxt.ofx;
    cy1_nxt = bk1_nxt.dy - bk1_nxt.ofy;
  end

  // stage 2: partial products of the four squares
  always_comb begin
    pcx2_nxt = split_sq(cx1_r);
    pcy2_nxt = split_sq(cy1_r);
    pox2_nxt = split_sq(bk1_r.ox);
    poy2_nxt = split_sq(bk1_r.oy);
  end

  // stage 5: keep the off-center point only when strictly closer
  always_comb begin
    if (od4_r < cd4_r) begin
      fx5_nxt  = bk4_r.ofx + bk4_r.ox;
      fy5_nxt  = bk4_r.ofy + bk4_r.oy;
      sat5_nxt = bk4_r.sato;
    end else begin
      fx5_nxt  = bk4_r.dx;
      fy5_nxt  = bk4_r.dy;
      sat5_nxt = bk4_r.satd;
    end
  end

  // stage 6: add to vertex a and saturate; a degenerate triangle yields vertex a
  always_comb begin
    logic signed [63:0] bx, by, px, py;
    logic               sfx, sfy;
    bx = 64'(ax5_r) <<< FB;
    by = 64'(ay5_r) <<< FB;
    px = sat48(bx + fx5_r, sfx);
    py = sat48(by + fy5_r, sfy);
    if (degen5_r) begin
      out6_nxt.point_x = tocp_pkg::OUT_W'(bx);
      out6_nxt.point_y = tocp_pkg::OUT_W'(by);
      out6_nxt.status  = tocp_pkg::ST_DEGEN;
    end else begin
      out6_nxt.point_x = tocp_pkg::OUT_W'(px);
      out6_nxt.point_y = tocp_pkg::OUT_W'(py);
      out6_nxt.status  = (sat5_r || sfx || sfy) ? tocp_pkg::ST_SAT : tocp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bk1_r    <= bk1_nxt;
      cx1_r    <= cx1_nxt;
      cy1_r    <= cy1_nxt;
      bk2_r    <= bk1_r;
      pcx2_r   <= pcx2_nxt;
      pcy2_r   <= pcy2_nxt;
      pox2_r   <= pox2_nxt;
      poy2_r   <= poy2_nxt;
      bk3_r    <= bk2_r;
      scx3_r   <= join_sq(pcx2_r);
      scy3_r   <= join_sq(pcy2_r);
      sox3_r   <= join_sq(pox2_r);
      soy3_r   <= join_sq(poy2_r);
      bk4_r    <= bk3_r;
      cd4_r    <= scx3_r + scy3_r;
      od4_r    <= sox3_r + soy3_r;
      fx5_r    <= fx5_nxt;
      fy5_r    <= fy5_nxt;
      sat5_r   <= sat5_nxt;
      degen5_r <= bk4_r.degen;
      ax5_r    <= bk4_r.ax;
      ay5_r    <= bk4_r.ay;
      out6_r   <= out6_nxt;
    end
  end

  assign out_vld  = v6_r;
  assign out_data = out6_r;

endmodule

`default_nettype wire

>>> rtl/core/triangle_offcenter_point_core.sv
// ----------------------------------------------------------------------------
// triangle_offcenter_point_core
// Off-center Steiner point of one integer-grid triangle per item.
//
// Channels: in_valid/in_stall/in_data carries one triangle per item,
// out_valid/out_stall/out_data one point and status per item. An item moves
// at a clock edge with valid high and stall low. cfg_valid/cfg_ready/cfg_data
// writes off_constant (unsigned, 16 fraction bits); cfg_ready is always high.
// Write it only while no item is in flight.
// Stages: a 69-stage one-bit-per-stage divider plus five front and six
// back stages. Throughput: one item per cycle when out_stall does not
// hold a waiting result.
// Reset (synchronous, rst_n low) empties the pipeline and sets off_constant
// to 1.0. When out_stall holds a waiting result, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_offcenter_point_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tocp_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tocp_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tocp_pkg::CFG_W-1:0]    cfg_data
);

  logic                         adv;
  logic [tocp_pkg::CFG_W-1:0]   off_constant_r;
  logic                         dv_vld, q_vld;
  tocp_pkg::side_t              dv_side, q_side;
  logic [tocp_pkg::DENW-1:0]    dv_den;
  logic [tocp_pkg::DVW-1:0]     dv_numx, dv_numy, q_x, q_y;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_constant_r <= tocp_pkg::OFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      off_constant_r <= cfg_data;
    end
  end

  tocp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_vld       (in_valid),
    .in_data      (in_data),
    .off_constant (off_constant_r),
    .dv_vld       (dv_vld),
    .dv_side      (dv_side),
    .dv_den       (dv_den),
    .dv_numx      (dv_numx),
    .dv_numy      (dv_numy)
  );

  tocp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (dv_vld),
    .in_side (dv_side),
    .in_den  (dv_den),
    .in_numx (dv_numx),
    .in_numy (dv_numy),
    .q_vld   (q_vld),
    .q_side  (q_side),
    .q_x     (q_x),
    .q_y     (q_y)
  );

  tocp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .q_vld    (q_vld),
    .q_side   (q_side),
    .q_x      (q_x),
    .q_y      (q_y),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == tocp_pkg::ST_OK ||
                   out_data.status == tocp_pkg::ST_DEGEN ||
                   out_data.status == tocp_pkg::ST_SAT))
    else $error("undefined status code");

  a_degen_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == tocp_pkg::ST_DEGEN) |->
      (out_data.point_x[tocp_pkg::FRAC_BITS-1:0] == '0 &&
       out_data.point_y[tocp_pkg::FRAC_BITS-1:0] == '0))
    else $error("degenerate result is not vertex a");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld && in_stall) |=> $stable(dv_numx))
    else $error("divider input moved under stall");

endmodule

`default_nettype wire
